// ----- src/cnap_pkg.sv -----
// Shared types, constants and character tables for the cpio newc parser.
// No dependencies; imported by every module of the block.
package cnap_pkg;

  localparam logic [6:0] HDR_LAST     = 7'd109;
  localparam logic [6:0] MAGIC_END    = 7'd6;
  localparam logic [6:0] FSIZE_FIRST  = 7'd54;
  localparam logic [6:0] FSIZE_END    = 7'd62;
  localparam logic [6:0] NSIZE_FIRST  = 7'd94;
  localparam logic [6:0] NSIZE_END    = 7'd102;
  localparam logic [31:0] TRAILER_LEN = 32'd10;
  localparam logic [31:0] TRAILER_MIN = 32'd11;

  localparam int RQ_DEPTH = 4;
  localparam int RQ_AW    = 2;
  localparam int RQ_CW    = 3;

  localparam logic KIND_RECORD = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  localparam logic [1:0] ST_TRAILER   = 2'd0;
  localparam logic [1:0] ST_CLEAN     = 2'd1;
  localparam logic [1:0] ST_BAD_MAGIC = 2'd2;
  localparam logic [1:0] ST_TRUNC     = 2'd3;

  typedef enum logic [2:0] {
    PH_HEADER = 3'd0,
    PH_NAME   = 3'd1,
    PH_NPAD   = 3'd2,
    PH_DATA   = 3'd3,
    PH_DPAD   = 3'd4,
    PH_DONE   = 3'd5
  } phase_t;

  typedef struct packed {
    logic [7:0] archive_byte;
    logic       end_of_buffer;
  } in_t;

  typedef struct packed {
    logic        kind;
    logic [5:0]  entry_index;
    logic [31:0] name_offset;
    logic [31:0] name_length;
    logic [31:0] data_offset;
    logic [31:0] data_size;
    logic [1:0]  status;
    logic [6:0]  file_count;
    logic        run_last;
  } out_t;

  // Results produced by one byte, packed low slot first.
  typedef struct packed {
    logic [1:0] n;
    out_t       r0;
    out_t       r1;
  } rq_push_t;

  function automatic logic [3:0] hex_digit(input logic [7:0] c);
    logic [3:0] d;
    d = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) d = 4'(c - 8'h30);
    else if (c >= 8'h61 && c <= 8'h66) d = 4'(c - 8'h57);
    else if (c >= 8'h41 && c <= 8'h46) d = 4'(c - 8'h37);
    return d;
  endfunction

  // "070701"
  function automatic logic [7:0] magic_char(input logic [2:0] i);
    logic [7:0] c;
    unique case (i)
      3'd0, 3'd2, 3'd4: c = 8'h30;
      3'd1, 3'd3:       c = 8'h37;
      default:          c = 8'h31;
    endcase
    return c;
  endfunction

  // "TRAILER!!!"
  function automatic logic [7:0] trailer_char(input logic [3:0] i);
    logic [7:0] c;
    unique case (i)
      4'd0:    c = 8'h54;
      4'd1:    c = 8'h52;
      4'd2:    c = 8'h41;
      4'd3:    c = 8'h49;
      4'd4:    c = 8'h4C;
      4'd5:    c = 8'h45;
      4'd6:    c = 8'h52;
      default: c = 8'h21;
    endcase
    return c;
  endfunction

endpackage

// ----- src/cnap_rq.sv -----
// Result queue: four entries, up to two pushes and one pop per cycle.
// Depends on cnap_pkg for the result and push types.
module cnap_rq
  import cnap_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  rq_push_t         push,
  input  logic             pop,
  output out_t             head,
  output logic [RQ_CW-1:0] cnt
);

  out_t             q_r [RQ_DEPTH];
  logic [RQ_AW-1:0] wptr_r, wptr_nxt;
  logic [RQ_AW-1:0] rptr_r, rptr_nxt;
  logic [RQ_CW-1:0] cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) q_r[wptr_r] <= push.r0;
    if (push.n == 2'd2) q_r[wptr_r + RQ_AW'(1)] <= push.r1;
  end

  always_comb begin
    wptr_nxt = wptr_r + RQ_AW'(push.n);
    rptr_nxt = rptr_r + RQ_AW'(pop);
    cnt_nxt  = cnt_r + RQ_CW'(push.n) - RQ_CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  assign head = q_r[rptr_r];
  assign cnt  = cnt_r;

endmodule

// ----- src/cnap_core.sv -----
// Parser state and per-byte update: header decode, name/data walk, records, status.
// Depends on cnap_pkg for phase codes, tables and result types.
module cnap_core
  import cnap_pkg::*;
#(
  parameter int MAX_ENTRIES = 64
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     step,
  input  in_t      item,
  output rq_push_t push
);

  localparam int CW = $clog2(MAX_ENTRIES + 1);

  phase_t        phase_r, phase_nxt;
  logic [6:0]    hpos_r, hpos_nxt;
  logic          magic_r, magic_nxt;
  logic [31:0]   nsz_r, nsz_nxt;
  logic [31:0]   fsz_r, fsz_nxt;
  logic [31:0]   boff_r, boff_nxt;
  logic [31:0]   rem_r, rem_nxt;
  logic [31:0]   nstart_r, nstart_nxt;
  logic [31:0]   dstart_r, dstart_nxt;
  logic          trl_r, trl_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  logic          rec_v, st_v;
  logic [CW-1:0] rec_idx, rec_cnt, st_cnt;
  logic [31:0]   rec_no, rec_nl, rec_do, rec_ds;
  logic [1:0]    st_code;
  logic [31:0]   name_idx;

  assign name_idx = nsz_r - rem_r;

  // Next state and result events for one byte.
  always_comb begin
    logic       hdr_done, nm_done, np_done, dt_done;
    logic [1:0] npad, dpad;
    logic [7:0] b;
    hdr_done   = 1'b0;
    nm_done    = 1'b0;
    np_done    = 1'b0;
    dt_done    = 1'b0;
    npad       = 2'd0;
    dpad       = 2'd0;
    b          = item.archive_byte;
    phase_nxt  = phase_r;
    hpos_nxt   = hpos_r;
    magic_nxt  = magic_r;
    nsz_nxt    = nsz_r;
    fsz_nxt    = fsz_r;
    boff_nxt   = boff_r;
    rem_nxt    = rem_r;
    nstart_nxt = nstart_r;
    dstart_nxt = dstart_r;
    trl_nxt    = trl_r;
    cnt_nxt    = cnt_r;
    rec_v      = 1'b0;
    rec_idx    = cnt_r;
    rec_cnt    = cnt_r;
    rec_no     = nstart_r;
    rec_nl     = nsz_r;
    rec_do     = dstart_r;
    rec_ds     = fsz_r;
    st_v       = 1'b0;
    st_code    = ST_TRAILER;
    st_cnt     = cnt_r;
    if (step) begin
      unique case (phase_r)
        PH_HEADER: begin
          if (hpos_r == 7'd0) begin
            magic_nxt = 1'b1;
            nsz_nxt   = '0;
            fsz_nxt   = '0;
          end
          if (hpos_r < MAGIC_END && b != magic_char(hpos_r[2:0])) magic_nxt = 1'b0;
          if (hpos_r >= FSIZE_FIRST && hpos_r < FSIZE_END)
            fsz_nxt = {fsz_nxt[27:0], hex_digit(b)};
          if (hpos_r >= NSIZE_FIRST && hpos_r < NSIZE_END)
            nsz_nxt = {nsz_nxt[27:0], hex_digit(b)};
          if (hpos_r == HDR_LAST) begin
            hpos_nxt = '0;
            if (!magic_nxt) begin
              st_v      = 1'b1;
              st_code   = ST_BAD_MAGIC;
              phase_nxt = PH_DONE;
            end else begin
              hdr_done = 1'b1;
            end
          end else begin
            hpos_nxt = hpos_r + 7'd1;
          end
        end
        PH_NAME: begin
          if (name_idx < TRAILER_LEN) begin
            if (b != trailer_char(name_idx[3:0])) trl_nxt = 1'b0;
          end else if (name_idx == TRAILER_LEN) begin
            if (b != 8'd0) trl_nxt = 1'b0;
          end
          rem_nxt = rem_r - 32'd1;
          if (rem_r == 32'd1) nm_done = 1'b1;
        end
        PH_NPAD: begin
          rem_nxt = rem_r - 32'd1;
          if (rem_r == 32'd1) np_done = 1'b1;
        end
        PH_DATA: begin
          rem_nxt = rem_r - 32'd1;
          if (rem_r == 32'd1) dt_done = 1'b1;
        end
        PH_DPAD: begin
          rem_nxt = rem_r - 32'd1;
          if (rem_r == 32'd1) begin
            phase_nxt = PH_HEADER;
            hpos_nxt  = '0;
          end
        end
        default: ;
      endcase

      if (hdr_done) begin
        nstart_nxt = boff_r + 32'd1;
        phase_nxt  = PH_NAME;
        rem_nxt    = nsz_nxt;
        trl_nxt    = (nsz_nxt >= TRAILER_MIN);
        if (nsz_nxt == 32'd0) nm_done = 1'b1;
      end
      // Header plus name is padded to four bytes.
      npad = 2'd2 - nsz_nxt[1:0];
      if (nm_done) begin
        phase_nxt = PH_NPAD;
        rem_nxt   = 32'(npad);
        if (npad == 2'd0) np_done = 1'b1;
      end
      if (np_done) begin
        dstart_nxt = boff_r + 32'd1;
        phase_nxt  = PH_DATA;
        rem_nxt    = fsz_nxt;
        if (fsz_nxt == 32'd0) dt_done = 1'b1;
      end
      dpad = 2'd0 - fsz_nxt[1:0];
      if (dt_done) begin
        if (trl_nxt) begin
          st_v      = 1'b1;
          st_code   = ST_TRAILER;
          phase_nxt = PH_DONE;
        end else begin
          if (cnt_r < CW'(MAX_ENTRIES)) begin
            rec_v   = 1'b1;
            cnt_nxt = cnt_r + CW'(1);
            rec_cnt = cnt_nxt;
            rec_no  = nstart_nxt;
            rec_nl  = nsz_nxt;
            rec_do  = dstart_nxt;
            rec_ds  = fsz_nxt;
          end
          if (dpad == 2'd0) begin
            phase_nxt = PH_HEADER;
            hpos_nxt  = '0;
          end else begin
            phase_nxt = PH_DPAD;
            rem_nxt   = 32'(dpad);
          end
        end
      end
      st_cnt = cnt_nxt;

      if (item.end_of_buffer) begin
        if (phase_nxt == PH_NAME || phase_nxt == PH_NPAD || phase_nxt == PH_DATA) begin
          st_v    = 1'b1;
          st_code = ST_TRUNC;
        end else if (phase_nxt == PH_HEADER || phase_nxt == PH_DPAD) begin
          st_v    = 1'b1;
          st_code = ST_CLEAN;
        end
        phase_nxt  = PH_HEADER;
        hpos_nxt   = '0;
        magic_nxt  = 1'b1;
        nsz_nxt    = '0;
        fsz_nxt    = '0;
        boff_nxt   = '0;
        rem_nxt    = '0;
        nstart_nxt = '0;
        dstart_nxt = '0;
        trl_nxt    = 1'b1;
        cnt_nxt    = '0;
      end else begin
        boff_nxt = boff_r + 32'd1;
      end
    end
  end

  // Result assembly: record first, then status.
  always_comb begin
    out_t       rec, st;
    logic [31:0] idx_w, rcnt_w, scnt_w;
    idx_w  = 32'(rec_idx);
    rcnt_w = 32'(rec_cnt);
    scnt_w = 32'(st_cnt);
    rec.kind        = KIND_RECORD;
    rec.entry_index = idx_w[5:0];
    rec.name_offset = rec_no;
    rec.name_length = rec_nl;
    rec.data_offset = rec_do;
    rec.data_size   = rec_ds;
    rec.status      = ST_TRAILER;
    rec.file_count  = rcnt_w[6:0];
    rec.run_last    = !st_v;
    st.kind         = KIND_STATUS;
    st.entry_index  = '0;
    st.name_offset  = '0;
    st.name_length  = '0;
    st.data_offset  = '0;
    st.data_size    = '0;
    st.status       = st_code;
    st.file_count   = scnt_w[6:0];
    st.run_last     = 1'b1;
    push.n  = 2'(rec_v) + 2'(st_v);
    push.r0 = rec_v ? rec : st;
    push.r1 = st;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HEADER;
      hpos_r   <= '0;
      magic_r  <= 1'b1;
      nsz_r    <= '0;
      fsz_r    <= '0;
      boff_r   <= '0;
      rem_r    <= '0;
      nstart_r <= '0;
      dstart_r <= '0;
      trl_r    <= 1'b1;
      cnt_r    <= '0;
    end else begin
      phase_r  <= phase_nxt;
      hpos_r   <= hpos_nxt;
      magic_r  <= magic_nxt;
      nsz_r    <= nsz_nxt;
      fsz_r    <= fsz_nxt;
      boff_r   <= boff_nxt;
      rem_r    <= rem_nxt;
      nstart_r <= nstart_nxt;
      dstart_r <= dstart_nxt;
      trl_r    <= trl_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// ----- src/cpio_newc_archive_parser.sv -----
// Top level of the cpio newc archive parser: input register, parser core, result queue.
// Depends on cnap_pkg, cnap_core and cnap_rq.
//
//   channel  dir  handshake            payload
//   in_      in   in_valid / in_stall  in_data  (archive_byte, end_of_buffer)
//   out_     out  out_valid/ out_stall out_data (one member record or final status)
//
// One archive byte per cycle while in_stall is low. A byte is held in the input
// register, parsed there, and its results are registered in the result queue for out_.
// A byte yielding a record and a status uses the single output port for both;
// the four-entry result queue sets how long input keeps flowing under out_stall.
// in_stall rises only when the input register is full and the queue holds more than
// two results. rst_n is synchronous and returns the parser to the start of an archive.
module cpio_newc_archive_parser
  import cnap_pkg::*;
#(
  parameter int MAX_ENTRIES = 64
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  logic             in_vld_r, in_vld_nxt;
  in_t              in_data_r;
  logic [RQ_CW-1:0] rq_cnt;
  logic             room, fire, take, pop;
  rq_push_t         push;

  // Parse the held byte only when the queue can absorb two results.
  assign room     = (rq_cnt <= RQ_CW'(RQ_DEPTH - 2));
  assign fire     = in_vld_r && room;
  assign in_stall = in_vld_r && !room;
  assign take     = in_valid && !in_stall;
  assign pop      = out_valid && !out_stall;

  // Hold the byte until it fires; refill in the same cycle it leaves.
  always_comb begin
    in_vld_nxt = in_vld_r;
    if (take) in_vld_nxt = 1'b1;
    else if (fire) in_vld_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) in_data_r <= in_data;
  end

  cnap_core #(
    .MAX_ENTRIES(MAX_ENTRIES)
  ) u_core (
    .clk  (clk),
    .rst_n(rst_n),
    .step (fire),
    .item (in_data_r),
    .push (push)
  );

  cnap_rq u_rq (
    .clk  (clk),
    .rst_n(rst_n),
    .push (push),
    .pop  (pop),
    .head (out_data),
    .cnt  (rq_cnt)
  );

  // Expose a result whenever the queue is not empty.
  assign out_valid = (rq_cnt != '0);

`ifndef SYNTHESIS
  a_rq_bound: assert property (@(posedge clk) disable iff (!rst_n)
    rq_cnt <= RQ_CW'(RQ_DEPTH))
    else $error("result queue overflow");

  a_pair_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !out_data.run_last) |=> (out_valid && out_data.kind == KIND_STATUS))
    else $error("record not followed by its status");

  a_in_held: assert property (@(posedge clk) disable iff (!rst_n)
    take |=> in_vld_r)
    else $error("accepted byte lost");
`endif

endmodule
